[hdl/hrc_pkg.sv]
// Shared package of the haversine radius classifier.
// Holds the fixed-point constants, the arctangent table, codes and the result type.
// Depends on nothing.
package hrc_pkg;

    localparam int CORDIC_STAGES = 24;
    localparam int SQRT_BITS     = 31;

    localparam int ANGLE_LAT = 6;
    localparam int ROT_LAT   = CORDIC_STAGES + 1;
    localparam int HAV_LAT   = 3;
    localparam int VEC_LAT   = CORDIC_STAGES + 1;
    localparam int DIST_LAT  = 1 + ANGLE_LAT + ROT_LAT + HAV_LAT + SQRT_BITS + VEC_LAT;

    localparam logic [28:0] UDEG_MUL = 29'((64'd3373259426 << 24) / 64'd180000000);
    localparam logic [32:0] PI_Q30      = 33'd3373259426;
    localparam logic [32:0] TWO_PI_Q30  = 33'd6746518852;
    localparam logic [32:0] HALF_PI_Q30 = 33'd1686629713;
    localparam logic [32:0] GAIN_Q30    = 33'd652032874;
    localparam logic [30:0] ONE_Q30     = 31'd1073741824;
    localparam logic [23:0] EARTH_DIAM_M = 24'd12742000;

    localparam logic [24:0] WALK_MUL = 25'(18 * (((64'd1 << 25) + 64'd24) / 64'd25));
    localparam int          WALK_SHIFT = 25;
    localparam logic [13:0] WALK_MAX = 14'd14400;
    localparam logic [14:0] RADIUS_RESET = 15'd1500;

    typedef enum logic [1:0] {
        MC_NONE  = 2'd0,
        MC_START = 2'd1,
        MC_GOAL  = 2'd2
    } t_match_class;

    typedef enum logic [2:0] {
        CFG_START_LAT = 3'd0,
        CFG_START_LON = 3'd1,
        CFG_GOAL_LAT  = 3'd2,
        CFG_GOAL_LON  = 3'd3,
        CFG_RADIUS    = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [15:0]  tag;
        t_match_class cls;
        logic [13:0]  walk;
        logic [24:0]  metres;
    } t_result;

    function automatic logic [31:0] f_atan(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd843314856;
            5'd1:  v = 32'd497837829;
            5'd2:  v = 32'd263043836;
            5'd3:  v = 32'd133525158;
            5'd4:  v = 32'd67021686;
            5'd5:  v = 32'd33543515;
            5'd6:  v = 32'd16775850;
            5'd7:  v = 32'd8388437;
            5'd8:  v = 32'd4194282;
            5'd9:  v = 32'd2097149;
            5'd10: v = 32'd1048575;
            5'd11: v = 32'd524287;
            5'd12: v = 32'd262143;
            5'd13: v = 32'd131071;
            5'd14: v = 32'd65535;
            5'd15: v = 32'd32767;
            5'd16: v = 32'd16383;
            5'd17: v = 32'd8191;
            5'd18: v = 32'd4095;
            5'd19: v = 32'd2047;
            5'd20: v = 32'd1023;
            5'd21: v = 32'd511;
            5'd22: v = 32'd255;
            5'd23: v = 32'd127;
            5'd24: v = 32'd63;
            5'd25: v = 32'd31;
            5'd26: v = 32'd15;
            5'd27: v = 32'd7;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

[hdl/hrc_angle.sv]
// Microdegree to Q30 radian conversion with reduction into [-pi/2, pi/2].
// Six register stages; depends on hrc_pkg.
module hrc_angle (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [29:0] i_value,
    input  logic               i_half,
    output logic signed [31:0] o_angle,
    output logic               o_flip
);

    logic        r_neg1, r_neg2, r_neg3, r_neg4, r_neg5;
    logic        r_half1, r_half2;
    logic [29:0] r_mag;
    logic [58:0] r_prod;
    logic [34:0] r_r;
    logic [32:0] r_m4;
    logic [32:0] r_m5;
    logic signed [31:0] r_angle;
    logic        r_flip;

    logic [58:0] n_prod;
    logic [59:0] n_sum;
    logic [34:0] n_r;
    logic [32:0] n_m4;
    logic [32:0] n_m5;
    logic        n_neg5;
    logic [32:0] n_m6;
    logic        n_flip;
    logic signed [32:0] n_angle;

    always_comb begin
        n_prod = {29'b0, r_mag} * {30'b0, hrc_pkg::UDEG_MUL};
        n_sum  = {1'b0, r_prod} + (r_half2 ? (60'd1 << 24) : (60'd1 << 23));
        n_r    = r_half2 ? n_sum[59:25] : n_sum[58:24];
        if (r_r >= {2'b0, hrc_pkg::TWO_PI_Q30}) begin
            n_m4 = 33'(r_r - {2'b0, hrc_pkg::TWO_PI_Q30});
        end else begin
            n_m4 = r_r[32:0];
        end
        if (r_m4 > hrc_pkg::PI_Q30) begin
            n_m5   = hrc_pkg::TWO_PI_Q30 - r_m4;
            n_neg5 = ~r_neg4;
        end else begin
            n_m5   = r_m4;
            n_neg5 = r_neg4;
        end
        if (r_m5 > hrc_pkg::HALF_PI_Q30) begin
            n_m6   = hrc_pkg::PI_Q30 - r_m5;
            n_flip = 1'b1;
        end else begin
            n_m6   = r_m5;
            n_flip = 1'b0;
        end
        n_angle = r_neg5 ? -signed'(n_m6) : signed'(n_m6);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg1  <= i_value[29];
            r_half1 <= i_half;
            r_mag   <= i_value[29] ? 30'(-i_value) : 30'(i_value);
            r_neg2  <= r_neg1;
            r_half2 <= r_half1;
            r_prod  <= n_prod;
            r_neg3  <= r_neg2;
            r_r     <= n_r;
            r_neg4  <= r_neg3;
            r_m4    <= n_m4;
            r_neg5  <= n_neg5;
            r_m5    <= n_m5;
            r_angle <= n_angle[31:0];
            r_flip  <= n_flip;
        end
    end

    assign o_angle = r_angle;
    assign o_flip  = r_flip;

endmodule

[hdl/hrc_rot.sv]
// Rotation-mode CORDIC giving sine and cosine of a reduced Q30 angle.
// One register per iteration plus an output register; depends on hrc_pkg.
module hrc_rot (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [31:0] i_angle,
    input  logic               i_flip,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);

    localparam int N = hrc_pkg::CORDIC_STAGES;

    logic signed [32:0] r_x [0:N-1];
    logic signed [32:0] r_y [0:N-1];
    logic signed [32:0] r_z [0:N-1];
    logic               r_f [0:N-1];
    logic signed [31:0] r_sin, r_cos;
    logic signed [32:0] n_cos;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic signed [32:0] a_x, a_y, a_z, n_x, n_y, n_z, a_atan;
            logic               a_f;
            if (g == 0) begin : g_first
                assign a_x = signed'(hrc_pkg::GAIN_Q30);
                assign a_y = '0;
                assign a_z = 33'(i_angle);
                assign a_f = i_flip;
            end else begin : g_next
                assign a_x = r_x[g-1];
                assign a_y = r_y[g-1];
                assign a_z = r_z[g-1];
                assign a_f = r_f[g-1];
            end
            assign a_atan = signed'({1'b0, hrc_pkg::f_atan(5'(g))});
            always_comb begin
                if (a_z >= 0) begin
                    n_x = a_x - (a_y >>> g);
                    n_y = a_y + (a_x >>> g);
                    n_z = a_z - a_atan;
                end else begin
                    n_x = a_x + (a_y >>> g);
                    n_y = a_y - (a_x >>> g);
                    n_z = a_z + a_atan;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g] <= n_x;
                    r_y[g] <= n_y;
                    r_z[g] <= n_z;
                    r_f[g] <= a_f;
                end
            end
        end
    endgenerate

    assign n_cos = r_f[N-1] ? -r_x[N-1] : r_x[N-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sin <= r_y[N-1][31:0];
            r_cos <= n_cos[31:0];
        end
    end

    assign o_sin = r_sin;
    assign o_cos = r_cos;

endmodule

[hdl/hrc_sqrt.sv]
// Pipelined integer square root, one result bit per register stage.
// Depends on hrc_pkg.
module hrc_sqrt (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [60:0] i_value,
    output logic [30:0] o_root
);

    localparam int N = hrc_pkg::SQRT_BITS;

    logic [60:0] r_v   [0:N-1];
    logic [61:0] r_res [0:N-1];

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            localparam logic [61:0] BIT = 62'd1 << (2 * (N - 1 - g));
            logic [60:0] a_v, n_v;
            logic [61:0] a_res, n_res, trial;
            if (g == 0) begin : g_first
                assign a_v   = i_value;
                assign a_res = '0;
            end else begin : g_next
                assign a_v   = r_v[g-1];
                assign a_res = r_res[g-1];
            end
            always_comb begin
                trial = a_res + BIT;
                if ({1'b0, a_v} >= trial) begin
                    n_v   = a_v - trial[60:0];
                    n_res = (a_res >> 1) + BIT;
                end else begin
                    n_v   = a_v;
                    n_res = a_res >> 1;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_v[g]   <= n_v;
                    r_res[g] <= n_res;
                end
            end
        end
    endgenerate

    assign o_root = r_res[N-1][30:0];

endmodule

[hdl/hrc_vec.sv]
// Vectoring-mode CORDIC for the central angle, then scaling to metres.
// One register per iteration plus the scaling register; depends on hrc_pkg.
module hrc_vec (
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [30:0] i_x,
    input  logic [30:0] i_y,
    output logic [24:0] o_dist
);

    localparam int N = hrc_pkg::CORDIC_STAGES;

    logic signed [32:0] r_x [0:N-1];
    logic signed [32:0] r_y [0:N-1];
    logic signed [32:0] r_z [0:N-1];
    logic [24:0]        r_dist;
    logic [31:0]        n_zc;
    logic [55:0]        n_prod;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_stage
            logic signed [32:0] a_x, a_y, a_z, n_x, n_y, n_z, a_atan;
            if (g == 0) begin : g_first
                assign a_x = signed'({2'b0, i_x});
                assign a_y = signed'({2'b0, i_y});
                assign a_z = '0;
            end else begin : g_next
                assign a_x = r_x[g-1];
                assign a_y = r_y[g-1];
                assign a_z = r_z[g-1];
            end
            assign a_atan = signed'({1'b0, hrc_pkg::f_atan(5'(g))});
            always_comb begin
                if (a_y > 0) begin
                    n_x = a_x + (a_y >>> g);
                    n_y = a_y - (a_x >>> g);
                    n_z = a_z + a_atan;
                end else begin
                    n_x = a_x - (a_y >>> g);
                    n_y = a_y + (a_x >>> g);
                    n_z = a_z - a_atan;
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_x[g] <= n_x;
                    r_y[g] <= n_y;
                    r_z[g] <= n_z;
                end
            end
        end
    endgenerate

    always_comb begin
        n_zc   = r_z[N-1][32] ? 32'd0 : r_z[N-1][31:0];
        n_prod = {24'b0, n_zc} * {32'b0, hrc_pkg::EARTH_DIAM_M};
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dist <= n_prod[54:30];
        end
    end

    assign o_dist = r_dist;

endmodule

[hdl/hrc_dist.sv]
// Haversine distance in metres between a reference point and a station.
// Uses hrc_angle, hrc_rot, hrc_sqrt and hrc_vec; depends on hrc_pkg.
module hrc_dist (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [27:0] i_ref_lat,
    input  logic signed [28:0] i_ref_lon,
    input  logic signed [27:0] i_stn_lat,
    input  logic signed [28:0] i_stn_lon,
    output logic [24:0]        o_dist
);

    logic signed [28:0] r_dlat;
    logic signed [29:0] r_dlon;
    logic signed [27:0] r_plat, r_qlat;

    logic signed [31:0] ang_dlat, ang_dlon, ang_plat, ang_qlat;
    logic               flp_dlat, flp_dlon, flp_plat, flp_qlat;
    logic signed [31:0] s_dlat, s_dlon, c_plat, c_qlat;

    logic signed [63:0] p_ll, p_cc, p_gg, p_t;
    logic signed [31:0] r_sl2, r_cc, r_sg2, r_sl2b, r_t;
    logic signed [32:0] n_h;
    logic [30:0]        n_hy;
    logic [30:0]        r_hx, r_hy;
    logic [30:0]        rt_x, rt_y;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dlat <= 29'(i_stn_lat) - 29'(i_ref_lat);
            r_dlon <= 30'(i_stn_lon) - 30'(i_ref_lon);
            r_plat <= i_ref_lat;
            r_qlat <= i_stn_lat;
        end
    end

    hrc_angle u_ang_dlat (.i_clk(i_clk), .i_en(i_en), .i_value(30'(r_dlat)), .i_half(1'b1),
                          .o_angle(ang_dlat), .o_flip(flp_dlat));
    hrc_angle u_ang_dlon (.i_clk(i_clk), .i_en(i_en), .i_value(r_dlon), .i_half(1'b1),
                          .o_angle(ang_dlon), .o_flip(flp_dlon));
    hrc_angle u_ang_plat (.i_clk(i_clk), .i_en(i_en), .i_value(30'(r_plat)), .i_half(1'b0),
                          .o_angle(ang_plat), .o_flip(flp_plat));
    hrc_angle u_ang_qlat (.i_clk(i_clk), .i_en(i_en), .i_value(30'(r_qlat)), .i_half(1'b0),
                          .o_angle(ang_qlat), .o_flip(flp_qlat));

    hrc_rot u_rot_dlat (.i_clk(i_clk), .i_en(i_en), .i_angle(ang_dlat), .i_flip(flp_dlat),
                        .o_sin(s_dlat), .o_cos());
    hrc_rot u_rot_dlon (.i_clk(i_clk), .i_en(i_en), .i_angle(ang_dlon), .i_flip(flp_dlon),
                        .o_sin(s_dlon), .o_cos());
    hrc_rot u_rot_plat (.i_clk(i_clk), .i_en(i_en), .i_angle(ang_plat), .i_flip(flp_plat),
                        .o_sin(), .o_cos(c_plat));
    hrc_rot u_rot_qlat (.i_clk(i_clk), .i_en(i_en), .i_angle(ang_qlat), .i_flip(flp_qlat),
                        .o_sin(), .o_cos(c_qlat));

    always_comb begin
        p_ll = 64'(s_dlat) * 64'(s_dlat);
        p_cc = 64'(c_plat) * 64'(c_qlat);
        p_gg = 64'(s_dlon) * 64'(s_dlon);
        p_t  = 64'(r_cc) * 64'(r_sg2);
        n_h  = 33'(r_sl2b) + 33'(r_t);
        if (n_h < 0) begin
            n_hy = '0;
        end else if (n_h > signed'({2'b0, hrc_pkg::ONE_Q30})) begin
            n_hy = hrc_pkg::ONE_Q30;
        end else begin
            n_hy = n_h[30:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sl2  <= p_ll[61:30];
            r_cc   <= p_cc[61:30];
            r_sg2  <= p_gg[61:30];
            r_sl2b <= r_sl2;
            r_t    <= p_t[61:30];
            r_hy   <= n_hy;
            r_hx   <= hrc_pkg::ONE_Q30 - n_hy;
        end
    end

    hrc_sqrt u_sqrt_x (.i_clk(i_clk), .i_en(i_en), .i_value({r_hx, 30'b0}), .o_root(rt_x));
    hrc_sqrt u_sqrt_y (.i_clk(i_clk), .i_en(i_en), .i_value({r_hy, 30'b0}), .o_root(rt_y));

    hrc_vec u_vec (.i_clk(i_clk), .i_en(i_en), .i_x(rt_x), .i_y(rt_y), .o_dist(o_dist));

endmodule

[hdl/haversine_radius_classifier_top.sv]
// Top level of the haversine radius classifier: configuration, two distance pipelines,
// classification, walking time and the output register with its skid entry.
// Depends on hrc_pkg and hrc_dist.
//
//   Channel  Handshake                   Payload
//   cfg      i_cfg_wr_en                 i_cfg_index, i_cfg_data
//   in       i_in_valid / o_in_ready     i_station_id, i_station_latitude, i_station_longitude
//   out      o_out_valid / i_out_ready   o_station_tag, o_match_class, o_walk_seconds,
//                                        o_distance_metres
//
// One item is taken every cycle while o_in_ready is high, that is while the skid entry is empty.
// Reset is synchronous; it clears the valid bits and the start and goal coordinates
// and loads the radius register with RADIUS_RESET.
// A result that is not taken waits in the output register; one more goes to the skid
// entry, and while that entry is full the whole pipeline holds and o_in_ready is low.
module haversine_radius_classifier_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_index,
    input  logic [28:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_station_id,
    input  logic signed [27:0] i_station_latitude,
    input  logic signed [28:0] i_station_longitude,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [15:0]        o_station_tag,
    output logic [1:0]         o_match_class,
    output logic [13:0]        o_walk_seconds,
    output logic [24:0]        o_distance_metres
);

    localparam int L = hrc_pkg::DIST_LAT;

    logic signed [27:0] r_start_lat, r_goal_lat;
    logic signed [28:0] r_start_lon, r_goal_lon;
    logic [14:0]        r_radius;

    logic        en;
    logic        r_vld [0:L-1];
    logic [15:0] r_id  [0:L-1];

    logic [24:0] d_start, d_goal;

    logic                  r_x_vld, r_y_vld;
    logic [15:0]           r_x_id, r_y_id;
    hrc_pkg::t_match_class r_x_cls, r_y_cls, n_x_cls;
    logic [24:0]           r_x_dist, r_y_dist, n_x_dist;
    logic [39:0]           r_y_prod;

    logic [14:0]       n_walk_raw;
    hrc_pkg::t_result  n_new;
    hrc_pkg::t_result  r_out, r_skd;
    logic              r_out_vld, r_skd_vld;
    logic              out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_lat <= '0;
            r_start_lon <= '0;
            r_goal_lat  <= '0;
            r_goal_lon  <= '0;
            r_radius    <= hrc_pkg::RADIUS_RESET;
        end else if (i_cfg_wr_en) begin
            case (hrc_pkg::t_cfg_reg'(i_cfg_index))
                hrc_pkg::CFG_START_LAT: r_start_lat <= i_cfg_data[27:0];
                hrc_pkg::CFG_START_LON: r_start_lon <= i_cfg_data;
                hrc_pkg::CFG_GOAL_LAT:  r_goal_lat  <= i_cfg_data[27:0];
                hrc_pkg::CFG_GOAL_LON:  r_goal_lon  <= i_cfg_data;
                hrc_pkg::CFG_RADIUS:    r_radius    <= i_cfg_data[14:0];
                default: ;
            endcase
        end
    end

    assign en         = !r_skd_vld;
    assign o_in_ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < L; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_x_vld <= 1'b0;
            r_y_vld <= 1'b0;
        end else if (en) begin
            r_vld[0] <= i_in_valid;
            for (int k = 1; k < L; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
            r_x_vld <= r_vld[L-1];
            r_y_vld <= r_x_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_id[0] <= i_station_id;
            for (int k = 1; k < L; k++) begin
                r_id[k] <= r_id[k-1];
            end
        end
    end

    hrc_dist u_dist_start (
        .i_clk(i_clk), .i_en(en),
        .i_ref_lat(r_start_lat), .i_ref_lon(r_start_lon),
        .i_stn_lat(i_station_latitude), .i_stn_lon(i_station_longitude),
        .o_dist(d_start)
    );

    hrc_dist u_dist_goal (
        .i_clk(i_clk), .i_en(en),
        .i_ref_lat(r_goal_lat), .i_ref_lon(r_goal_lon),
        .i_stn_lat(i_station_latitude), .i_stn_lon(i_station_longitude),
        .o_dist(d_goal)
    );

    always_comb begin
        if (d_start < {10'b0, r_radius}) begin
            n_x_cls  = hrc_pkg::MC_START;
            n_x_dist = d_start;
        end else if (d_goal < {10'b0, r_radius}) begin
            n_x_cls  = hrc_pkg::MC_GOAL;
            n_x_dist = d_goal;
        end else begin
            n_x_cls  = hrc_pkg::MC_NONE;
            n_x_dist = d_goal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x_id   <= r_id[L-1];
            r_x_cls  <= n_x_cls;
            r_x_dist <= n_x_dist;
            r_y_id   <= r_x_id;
            r_y_cls  <= r_x_cls;
            r_y_dist <= r_x_dist;
            r_y_prod <= {25'b0, r_x_dist[14:0]} * {15'b0, hrc_pkg::WALK_MUL};
        end
    end

    always_comb begin
        n_walk_raw   = r_y_prod[hrc_pkg::WALK_SHIFT +: 15];
        n_new.tag    = r_y_id;
        n_new.cls    = r_y_cls;
        n_new.metres = r_y_dist;
        if (r_y_cls == hrc_pkg::MC_NONE) begin
            n_new.walk = '0;
        end else if (n_walk_raw > {1'b0, hrc_pkg::WALK_MAX}) begin
            n_new.walk = hrc_pkg::WALK_MAX;
        end else begin
            n_new.walk = n_walk_raw[13:0];
        end
    end

    assign out_free = !r_out_vld || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
            r_skd_vld <= 1'b0;
        end else begin
            if (out_free) begin
                r_out_vld <= r_skd_vld || r_y_vld;
                r_skd_vld <= 1'b0;
            end else if (en && r_y_vld) begin
                r_skd_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out <= r_skd_vld ? r_skd : n_new;
        end else if (en && r_y_vld) begin
            r_skd <= n_new;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_station_tag     = r_out.tag;
    assign o_match_class     = r_out.cls;
    assign o_walk_seconds    = r_out.walk;
    assign o_distance_metres = r_out.metres;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_vld |-> r_out_vld)
        else $error("skid entry holds an item while the output register is empty");

    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skd_vld) |-> $past(r_out_vld && !i_out_ready))
        else $error("skid entry filled while the output was free");

    a_class_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_match_class == hrc_pkg::MC_NONE ||
                         o_match_class == hrc_pkg::MC_START ||
                         o_match_class == hrc_pkg::MC_GOAL))
        else $error("invalid match class on the output");

    a_walk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_class == hrc_pkg::MC_NONE) |-> (o_walk_seconds == '0))
        else $error("walking time given for an item without a match");

    a_near_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_match_class != hrc_pkg::MC_NONE) |->
            (o_distance_metres < {10'b0, r_radius}))
        else $error("matched item lies outside the radius");

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench of haversine_radius_classifier_top: directed table, then random phases.
// Predicts each result with its own fixed-point haversine model and checks it field by field.
// Depends on hrc_pkg and the classifier RTL.
module testbench;

    localparam int         RUN_LIMIT   = 400000;
    localparam int         HOLD_CYCLES = 300;
    localparam logic [2:0] CFG_UNUSED  = 3'd7;
    localparam longint     UDEG_TO_RAD = (64'sd3373259426 * 64'sd16777216) / 64'sd180000000;
    localparam longint     PI_RAD      = 64'sd3373259426;
    localparam longint     TWO_PI_RAD  = 64'sd6746518852;
    localparam longint     HALF_PI_RAD = 64'sd1686629713;
    localparam longint     UNIT        = 64'sd1073741824;
    localparam longint     VEC_GAIN    = 64'sd652032874;

    typedef enum logic { ROW_ITEM, ROW_CFG } t_row_kind;
    typedef struct {
        t_row_kind kind;
        int        a;
        int        b;
        int        c;
        int        cls;
    } t_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_wr_en = 1'b0;
    logic [2:0]         i_cfg_index = '0;
    logic [28:0]        i_cfg_data = '0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic [15:0]        i_station_id = '0;
    logic signed [27:0] i_station_latitude = '0;
    logic signed [28:0] i_station_longitude = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [15:0]        o_station_tag;
    logic [1:0]         o_match_class;
    logic [13:0]        o_walk_seconds;
    logic [24:0]        o_distance_metres;

    logic signed [27:0] start_lat_q = '0;
    logic signed [28:0] start_lon_q = '0;
    logic signed [27:0] goal_lat_q = '0;
    logic signed [28:0] goal_lon_q = '0;
    logic [14:0]        radius_q = hrc_pkg::RADIUS_RESET;

    hrc_pkg::t_result pending_results[$];
    longint  arctan_q30[32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
        33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31, 15, 7, 3, 1, 0, 0};
    int      mismatches = 0;
    int      cycles = 0;
    bit      idling_on = 1'b1;
    bit      hold_request = 1'b0;
    bit      hold_active = 1'b0;
    int      stall_left = 0;
    t_row    rows[$];

    haversine_radius_classifier_top i_dut (.*);

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > RUN_LIMIT) begin
            $display("haversine_radius_classifier_top regression: fail");
            $finish;
        end
    end

    function automatic longint to_radians(longint udeg, int shift);
        longint mag;
        longint r;
        mag = (udeg < 0) ? -udeg : udeg;
        r = (mag * UDEG_TO_RAD + (64'sd1 <<< (shift - 1))) >>> shift;
        return (udeg < 0) ? -r : r;
    endfunction

    function automatic void rotate(input longint a, output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        r = a % TWO_PI_RAD;
        x = VEC_GAIN;
        y = 0;
        flip = 1'b0;
        if (r > PI_RAD) r -= TWO_PI_RAD;
        else if (r < -PI_RAD) r += TWO_PI_RAD;
        if (r > HALF_PI_RAD) begin
            r = PI_RAD - r;
            flip = 1'b1;
        end else if (r < -HALF_PI_RAD) begin
            r = -PI_RAD - r;
            flip = 1'b1;
        end
        for (int i = 0; i < hrc_pkg::CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0) begin
                x -= dx; y += dy; r -= arctan_q30[i];
            end else begin
                x += dx; y -= dy; r += arctan_q30[i];
            end
        end
        s = y;
        c = flip ? -x : x;
    endfunction

    function automatic longint root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= res + b) begin
                v -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint great_circle_m(longint plat, longint plon,
                                              longint qlat, longint qlon);
        longint sl, sg, c1, c2, spare, h, x, y, z, dx, dy;
        rotate(to_radians(qlat - plat, 25), sl, spare);
        rotate(to_radians(qlon - plon, 25), sg, spare);
        rotate(to_radians(plat, 24), spare, c1);
        rotate(to_radians(qlat, 24), spare, c2);
        h = ((sl * sl) >>> 30) + ((((c1 * c2) >>> 30) * ((sg * sg) >>> 30)) >>> 30);
        if (h < 0) h = 0;
        if (h > UNIT) h = UNIT;
        x = root_floor((UNIT - h) <<< 30);
        y = root_floor(h <<< 30);
        z = 0;
        for (int i = 0; i < hrc_pkg::CORDIC_STAGES && i < 32; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y > 0) begin
                x += dx; y -= dy; z += arctan_q30[i];
            end else begin
                x -= dx; y += dy; z -= arctan_q30[i];
            end
        end
        if (z < 0) z = 0;
        return (z * 64'sd12742000) >>> 30;
    endfunction

    function automatic hrc_pkg::t_result classify_station(logic [15:0] id,
                                                          logic signed [27:0] lat,
                                                          logic signed [28:0] lon);
        hrc_pkg::t_result r;
        longint  d;
        longint  w;
        r.tag = id;
        r.cls = hrc_pkg::MC_NONE;
        w = 0;
        d = great_circle_m(start_lat_q, start_lon_q, lat, lon);
        if (d < longint'(radius_q)) begin
            r.cls = hrc_pkg::MC_START;
        end else begin
            d = great_circle_m(goal_lat_q, goal_lon_q, lat, lon);
            if (d < longint'(radius_q)) r.cls = hrc_pkg::MC_GOAL;
        end
        if (r.cls != hrc_pkg::MC_NONE) begin
            w = d * 18 / 25;
            if (w > 14400) w = 14400;
        end
        r.walk = w[13:0];
        r.metres = d[24:0];
        return r;
    endfunction

    task automatic report(string field, longint got, longint want);
        $display("mismatch in %s: got %0d, expected %0d", field, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        hrc_pkg::t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected item tag", o_station_tag, -1);
            end else begin
                want = pending_results.pop_front();
                if (o_station_tag !== want.tag) report("station_tag", o_station_tag, want.tag);
                if (o_match_class !== want.cls) report("match_class", o_match_class, want.cls);
                if (o_walk_seconds !== want.walk)
                    report("walk_seconds", o_walk_seconds, want.walk);
                if (o_distance_metres !== want.metres)
                    report("distance_metres", o_distance_metres, want.metres);
            end
        end
        if (hold_active) begin
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_ready <= 1'b0;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    initial begin
        wait (hold_request);
        @(posedge i_clk);
        hold_active = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_active = 1'b0;
    end

    task automatic write_reg(logic [2:0] idx, logic [28:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        case (idx)
            hrc_pkg::CFG_START_LAT: start_lat_q = data[27:0];
            hrc_pkg::CFG_START_LON: start_lon_q = data;
            hrc_pkg::CFG_GOAL_LAT:  goal_lat_q  = data[27:0];
            hrc_pkg::CFG_GOAL_LON:  goal_lon_q  = data;
            hrc_pkg::CFG_RADIUS:    radius_q    = data[14:0];
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_item(logic [15:0] id, logic [27:0] lat, logic [28:0] lon, int cls);
        hrc_pkg::t_result want;
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        i_in_valid          <= 1'b1;
        i_station_id        <= id;
        i_station_latitude  <= lat;
        i_station_longitude <= lon;
        do @(posedge i_clk); while (!o_in_ready);
        want = classify_station(id, lat, lon);
        if (cls >= 0) want.cls = hrc_pkg::t_match_class'(cls);
        pending_results.insert(pending_results.size(), want);
    endtask

    initial begin
        int phase_items;
        int lat;
        int lon;
        int span;
        bit cfg_open;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        rows = '{
            '{ROW_ITEM, 0, 0, 0, hrc_pkg::MC_START},
            '{ROW_ITEM, 65535, 0, 180000000, hrc_pkg::MC_NONE},
            '{ROW_ITEM, 1, 90000000, 0, hrc_pkg::MC_NONE},
            '{ROW_ITEM, 2, -90000000, -180000000, hrc_pkg::MC_NONE},
            '{ROW_ITEM, 3, 134217727, 268435455, -1},
            '{ROW_ITEM, 4, -134217728, -268435456, -1},
            '{ROW_ITEM, 5, 10000, 0, hrc_pkg::MC_START},
            '{ROW_CFG, hrc_pkg::CFG_START_LAT, 45000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_START_LON, 7000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_GOAL_LAT, -33000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_GOAL_LON, 151000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_RADIUS, 20000, 0, -1},
            '{ROW_ITEM, 6, 45000000, 7000000, hrc_pkg::MC_START},
            '{ROW_ITEM, 7, -33050000, 151050000, hrc_pkg::MC_GOAL},
            '{ROW_ITEM, 8, 0, 0, hrc_pkg::MC_NONE},
            '{ROW_CFG, hrc_pkg::CFG_RADIUS, 0, 0, -1},
            '{ROW_ITEM, 9, 45000000, 7000000, hrc_pkg::MC_NONE},
            '{ROW_CFG, hrc_pkg::CFG_RADIUS, 32767, 0, -1},
            '{ROW_ITEM, 10, 45220000, 7000000, -1},
            '{ROW_ITEM, 11, -33000000, 151000000, hrc_pkg::MC_GOAL},
            '{ROW_CFG, hrc_pkg::CFG_START_LAT, -90000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_START_LON, -180000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_GOAL_LAT, 90000000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_GOAL_LON, 180000000, 0, -1},
            '{ROW_CFG, CFG_UNUSED, 12345, 0, -1},
            '{ROW_ITEM, 12, -90000000, 0, -1},
            '{ROW_ITEM, 13, 90000000, 180000000, -1},
            '{ROW_ITEM, 14, 89990000, 0, -1},
            '{ROW_CFG, hrc_pkg::CFG_START_LAT, 536870911, 0, -1},
            '{ROW_ITEM, 15, 134217727, -268435456, -1}
        };
        cfg_open = 1'b0;
        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                if (!cfg_open) wait_drained();
                cfg_open = 1'b1;
                write_reg(rows[k].a[2:0], rows[k].b[28:0]);
            end else begin
                if (cfg_open) i_cfg_wr_en <= 1'b0;
                cfg_open = 1'b0;
                send_item(rows[k].a[15:0], rows[k].b[27:0], rows[k].c[28:0], rows[k].cls);
            end
        end

        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            idling_on = (phase < 5);
            if (phase == 1) begin
                write_reg(hrc_pkg::CFG_START_LAT, 29'(-90000000));
                write_reg(hrc_pkg::CFG_START_LON, 29'(180000000));
                write_reg(hrc_pkg::CFG_GOAL_LAT, 29'(90000000));
                write_reg(hrc_pkg::CFG_GOAL_LON, 29'(-180000000));
                write_reg(hrc_pkg::CFG_RADIUS, 29'd32767);
            end else begin
                write_reg(hrc_pkg::CFG_START_LAT,
                          29'($urandom_range(0, 180000000) - 90000000));
                write_reg(hrc_pkg::CFG_START_LON,
                          29'($urandom_range(0, 360000000) - 180000000));
                write_reg(hrc_pkg::CFG_GOAL_LAT,
                          29'($urandom_range(0, 180000000) - 90000000));
                write_reg(hrc_pkg::CFG_GOAL_LON,
                          29'($urandom_range(0, 360000000) - 180000000));
                write_reg(hrc_pkg::CFG_RADIUS,
                          (phase == 3) ? 29'd0 : 29'($urandom_range(0, 32767)));
            end
            i_cfg_wr_en <= 1'b0;
            span = 400000;
            phase_items = 200;
            for (int n = 0; n < phase_items; n++) begin
                if (phase == 1 && n == 20) hold_request = 1'b1;
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: begin
                        lat = int'(start_lat_q) + $urandom_range(0, 2 * span) - span;
                        lon = int'(start_lon_q) + $urandom_range(0, 2 * span) - span;
                    end
                    4, 5, 6: begin
                        lat = int'(goal_lat_q) + $urandom_range(0, 2 * span) - span;
                        lon = int'(goal_lon_q) + $urandom_range(0, 2 * span) - span;
                    end
                    default: begin
                        lat = $urandom();
                        lon = $urandom();
                    end
                endcase
                send_item(16'($urandom()), lat[27:0], lon[28:0], -1);
            end
        end

        wait_drained();
        repeat (hrc_pkg::DIST_LAT + 20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("haversine_radius_classifier_top regression: pass");
        end else begin
            $display("haversine_radius_classifier_top regression: fail");
        end
        $finish;
    end

endmodule
